FILE: rtl/lr_pkg.sv
// shared types and constants for the line rasterizer
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_BITS  = 10;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int STR_BITS    = COORD_BITS + 2;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [COORD_BITS-1:0] coord_t;

  // item opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // input item
  typedef struct packed {
    opcode_t opcode;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
  } in_item_t;

  // result item
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic   is_start;
    coord_t x0;
    coord_t y0;
    coord_t dmaj;
    coord_t dmin;
    logic   major_is_x;
    logic   x_neg;
    logic   y_neg;
  } lr_cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/lr_front.sv
// front stage: accepts items, works out deltas, directions and major axis
`timescale 1ns / 1ps
`default_nettype none

module lr_front
  import lr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  input  wire q_status_t q_status,
  output logic           q_push,
  output lr_cmd_t        q_cmd
);

  logic    cmd_valid_r, cmd_valid_nxt;
  lr_cmd_t cmd_r, cmd_nxt;
  logic    in_xfer;

  logic [COORD_BITS:0] diff_x, diff_y;
  coord_t              abs_x, abs_y;
  logic                maj_x;

  // absolute deltas and step directions
  assign diff_x = {1'b0, in_data.x_end} - {1'b0, in_data.x_start};
  assign diff_y = {1'b0, in_data.y_end} - {1'b0, in_data.y_start};
  assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
  // equal deltas make y the major axis
  assign maj_x  = abs_x > abs_y;

  always_comb begin
    cmd_nxt            = cmd_r;
    if (in_xfer) begin
      cmd_nxt.is_start   = (in_data.opcode == OP_START);
      cmd_nxt.x0         = in_data.x_start;
      cmd_nxt.y0         = in_data.y_start;
      cmd_nxt.dmaj       = maj_x ? abs_x : abs_y;
      cmd_nxt.dmin       = maj_x ? abs_y : abs_x;
      cmd_nxt.major_is_x = maj_x;
      cmd_nxt.x_neg      = diff_x[COORD_BITS];
      cmd_nxt.y_neg      = diff_y[COORD_BITS];
    end
  end

  // hold stage: stalls only while its command cannot enter the queue
  assign in_stall = cmd_valid_r && q_status.full;
  assign in_xfer  = in_valid && !in_stall;
  assign q_push   = cmd_valid_r && !q_status.full;
  assign q_cmd    = cmd_r;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (in_xfer) begin
      cmd_valid_nxt = 1'b1;
    end else if (q_push) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/lr_queue.sv
// command queue between front and back stages
`timescale 1ns / 1ps
`default_nettype none

module lr_queue
  import lr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire lr_cmd_t push_cmd,
  input  wire logic    pop,
  output lr_cmd_t      head_cmd,
  output q_status_t    status
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  lr_cmd_t               mem [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd      = mem[rd_ptr_r];
  assign status.empty  = (cnt_r == '0);
  assign status.full   = (cnt_r == CNT_BITS'(DEPTH));

  // pointer and fill count update with wrap at depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lr_back.sv
// back stage: line state, error-term stepping and output register
`timescale 1ns / 1ps
`default_nettype none

module lr_back
  import lr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  input  wire lr_cmd_t   head_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  coord_t                cur_x_r, cur_x_nxt;
  coord_t                cur_y_r, cur_y_nxt;
  logic [ERR_BITS-1:0]   err_r, err_nxt;
  logic [ERR_BITS-1:0]   diag_r, diag_nxt;
  logic [STR_BITS-1:0]   straight_r, straight_nxt;
  coord_t                steps_r, steps_nxt;
  logic                  major_x_r, major_x_nxt;
  logic                  x_neg_r, x_neg_nxt;
  logic                  y_neg_r, y_neg_nxt;
  logic                  active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_take;
  logic                  gen;
  logic                  move_minor;
  coord_t                step_x, step_y;

  // pop whenever the output register is free or being emptied
  assign out_take = out_valid_r && !out_stall;
  assign q_pop    = !q_status.empty && (!out_valid_r || !out_stall);

  // neighbor pixel in each direction
  assign move_minor = !err_r[ERR_BITS-1];
  assign step_x     = x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
  assign step_y     = y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;

  always_comb begin
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    err_nxt      = err_r;
    diag_nxt     = diag_r;
    straight_nxt = straight_r;
    steps_nxt    = steps_r;
    major_x_nxt  = major_x_r;
    x_neg_nxt    = x_neg_r;
    y_neg_nxt    = y_neg_r;
    active_nxt   = active_r;
    out_nxt      = out_r;
    gen          = 1'b0;
    if (q_pop) begin
      if (head_cmd.is_start) begin
        // new line setup, first pixel is the start point
        cur_x_nxt    = head_cmd.x0;
        cur_y_nxt    = head_cmd.y0;
        err_nxt      = {2'b00, head_cmd.dmin, 1'b0} - {3'b000, head_cmd.dmaj};
        diag_nxt     = {2'b00, head_cmd.dmin, 1'b0} - {2'b00, head_cmd.dmaj, 1'b0};
        straight_nxt = {head_cmd.dmin, 1'b0};
        steps_nxt    = head_cmd.dmaj;
        major_x_nxt  = head_cmd.major_is_x;
        x_neg_nxt    = head_cmd.x_neg;
        y_neg_nxt    = head_cmd.y_neg;
        active_nxt   = (head_cmd.dmaj != '0);
        gen          = 1'b1;
        out_nxt.pixel_x    = head_cmd.x0;
        out_nxt.pixel_y    = head_cmd.y0;
        out_nxt.last_pixel = (head_cmd.dmaj == '0);
      end else if (active_r) begin
        // one step along the major axis, minor axis on non-negative error
        if (major_x_r) begin
          cur_x_nxt = step_x;
          if (move_minor) begin
            cur_y_nxt = step_y;
          end
        end else begin
          cur_y_nxt = step_y;
          if (move_minor) begin
            cur_x_nxt = step_x;
          end
        end
        if (move_minor) begin
          err_nxt = err_r + diag_r;
        end else begin
          err_nxt = err_r + {1'b0, straight_r};
        end
        steps_nxt  = steps_r - 1'b1;
        active_nxt = (steps_nxt != '0);
        gen        = 1'b1;
        out_nxt.pixel_x    = cur_x_nxt;
        out_nxt.pixel_y    = cur_y_nxt;
        out_nxt.last_pixel = (steps_nxt == '0);
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_r       <= '0;
      diag_r      <= '0;
      straight_r  <= '0;
      steps_r     <= '0;
      major_x_r   <= 1'b0;
      x_neg_r     <= 1'b0;
      y_neg_r     <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      diag_r      <= diag_nxt;
      straight_r  <= straight_nxt;
      steps_r     <= steps_nxt;
      major_x_r   <= major_x_nxt;
      x_neg_r     <= x_neg_nxt;
      y_neg_r     <= y_neg_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: rtl/line_rasterizer_unit.sv
// line rasterizer top level: front stage, command queue, back stage
//
// Input channel in_valid / in_stall / in_data carries start items (two
// endpoints) and step items. Each start gives the line's first pixel; each
// step while a line is active gives the next pixel, and a step with no
// active line gives nothing. out_valid / out_stall / out_data carries the
// pixels, last_pixel set on the line's final endpoint.
// Path: an item is registered in the front register, written into the queue,
// then taken from the queue head into the output register.
// Throughput: one item per clock while out_stall stays low, limited by the
// error-term add and compare in the back stage.
// Reset clears the front register, the queue and the line state; no line
// is active afterwards. While out_stall is high the back stage holds its
// pixel, the queue fills (QUEUE_DEPTH entries plus the front register),
// and only then does in_stall rise.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_unit
  import lr_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  lr_cmd_t   q_cmd;
  lr_cmd_t   head_cmd;

  // item classification
  lr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // decoupling queue
  lr_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // pixel stepping
  lr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // queue never both full and empty
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  // no push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !q_push)
    else $error("push into full queue");

  // no pop from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // a new result only follows a queue pop
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result without a popped command");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for line_rasterizer_unit: directed table, random lines, then one long line
`timescale 1ns / 1ps

module tb_top;
  import lr_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     PHASE_PIXELS  = 100;
  localparam int     LONG_STEPS    = 150;
  localparam int     DRAIN_CYCLES  = 12;
  localparam int     DIR_ROWS      = 25;
  localparam int     COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam coord_t CMAX          = '1;
  localparam coord_t CZERO         = '0;
  localparam out_item_t NO_PIXEL   = '0;

  // directed row: the item, plus a pixel typed in by hand where it is obvious
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    logic      has_pixel;
    out_item_t pixel;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct    = 33;
  int stall_pct   = 82;
  int err_count   = 0;
  int cycle_count = 0;
  int pixels_sent = 0;

  out_item_t pixel_queue[$];
  dir_row_t  dir_table [DIR_ROWS];

  // mirror of the line state
  coord_t                     cur_x        = '0;
  coord_t                     cur_y        = '0;
  coord_t                     steps_left   = '0;
  logic signed [ERR_BITS-1:0] err_acc      = '0;
  logic signed [ERR_BITS-1:0] diag_inc     = '0;
  logic [STR_BITS-1:0]        straight_inc = '0;
  logic                       major_x      = 1'b0;
  logic                       x_neg        = 1'b0;
  logic                       y_neg        = 1'b0;
  logic                       active       = 1'b0;

  line_rasterizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic in_item_t start_item(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    return '{OP_START, xs, ys, xe, ye};
  endfunction

  // step items carry random junk in the unused coordinate fields
  function automatic in_item_t step_item();
    return '{OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic out_item_t pix(coord_t x, coord_t y, logic last);
    return '{x, y, last};
  endfunction

  function automatic coord_t step_coord(coord_t c, logic neg);
    return neg ? c - 1'b1 : c + 1'b1;
  endfunction

  // endpoint a few pixels from c, mirrored back inside the coordinate range
  function automatic int near_coord(int c);
    int e;
    e = $urandom_range(0, 1) ? c + int'($urandom_range(0, 12)) : c - int'($urandom_range(0, 12));
    if (e > COORD_MAX || e < 0) e = 2 * c - e;
    return e;
  endfunction

  // bresenham prediction: updates the mirror, returns 1 when a pixel comes out
  function automatic logic rasterize(input in_item_t it, output out_item_t p);
    int dx;
    int dy;
    int dmaj;
    int dmin;
    p = NO_PIXEL;
    if (it.opcode == OP_START) begin
      dx = int'(it.x_end) - int'(it.x_start);
      dy = int'(it.y_end) - int'(it.y_start);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      x_neg = it.x_end < it.x_start;
      y_neg = it.y_end < it.y_start;
      // equal deltas fall to the y axis
      major_x = dx > dy;
      dmaj = major_x ? dx : dy;
      dmin = major_x ? dy : dx;
      cur_x = it.x_start;
      cur_y = it.y_start;
      err_acc = ERR_BITS'(2 * dmin - dmaj);
      diag_inc = ERR_BITS'(2 * (dmin - dmaj));
      straight_inc = STR_BITS'(2 * dmin);
      steps_left = coord_t'(dmaj);
      active = dmaj != 0;
      p = pix(cur_x, cur_y, dmaj == 0);
      return 1'b1;
    end
    if (!active) return 1'b0;
    // minor axis moves on a non-negative error
    if (err_acc >= 0) begin
      if (major_x) cur_y = step_coord(cur_y, y_neg);
      else cur_x = step_coord(cur_x, x_neg);
      err_acc = err_acc + diag_inc;
    end else begin
      err_acc = err_acc + $signed({1'b0, straight_inc});
    end
    if (major_x) cur_x = step_coord(cur_x, x_neg);
    else cur_y = step_coord(cur_y, y_neg);
    steps_left = steps_left - 1'b1;
    if (steps_left == '0) active = 1'b0;
    p = pix(cur_x, cur_y, steps_left == '0);
    return 1'b1;
  endfunction

  // one input transfer with random idle cycles ahead of it
  task automatic send_item(input in_item_t it, output logic produced, output out_item_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    produced = rasterize(it, p);
  endtask

  task automatic expect_item(input in_item_t it);
    logic      produced;
    out_item_t p;
    send_item(it, produced, p);
    if (produced) begin
      pixel_queue.push_back(p);
      pixels_sent++;
    end
  endtask

  task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                           input int n_steps);
    expect_item(start_item(coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye)));
    repeat (n_steps) expect_item(step_item());
  endtask

  // mostly short well-formed lines; some cut short, overrun, or far-flung
  task automatic random_lines(input int target);
    int first;
    int xs;
    int ys;
    int xe;
    int ye;
    int dx;
    int dy;
    int dmaj;
    int n_steps;
    first = pixels_sent;
    while (pixels_sent - first < target) begin
      if ($urandom_range(0, 9) == 0) expect_item(step_item());
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      if ($urandom_range(0, 9) == 0) begin
        xe = $urandom_range(0, COORD_MAX);
        ye = $urandom_range(0, COORD_MAX);
        n_steps = $urandom_range(0, 40);
      end else begin
        xe = near_coord(xs);
        ye = near_coord(ys);
        dx = xe > xs ? xe - xs : xs - xe;
        dy = ye > ys ? ye - ys : ys - ye;
        dmaj = dx > dy ? dx : dy;
        case ($urandom_range(0, 7))
          0: n_steps = $urandom_range(0, dmaj);
          1: n_steps = dmaj + $urandom_range(1, 2);
          default: n_steps = dmaj;
        endcase
      end
      draw_line(xs, ys, xe, ye, n_steps);
    end
  endtask

  // result side: random stall, compare each pixel transfer
  always @(posedge clk) begin
    out_item_t want;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_queue.size() == 0) begin
        $display("%0t: pixel with none expected: got (%0d,%0d) last %0d", $time,
                 out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
        err_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (want.pixel_x !== out_data.pixel_x || want.pixel_y !== out_data.pixel_y ||
            want.last_pixel !== out_data.last_pixel) begin
          $display("%0t: pixel mismatch: expected (%0d,%0d) last %0d, got (%0d,%0d) last %0d",
                   $time, want.pixel_x, want.pixel_y, want.last_pixel,
                   out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic      produced;
    out_item_t p;

    dir_table = '{
      // step with no line after reset
      '{step_item(), 1'b1, 1'b0, NO_PIXEL},
      // single-point lines at both corners leave nothing active
      '{start_item(CZERO, CZERO, CZERO, CZERO), 1'b1, 1'b1, pix(CZERO, CZERO, 1'b1)},
      '{'{OP_STEP, CMAX, CMAX, CMAX, CMAX}, 1'b1, 1'b0, NO_PIXEL},
      '{start_item(CMAX, CMAX, CMAX, CMAX), 1'b1, 1'b1, pix(CMAX, CMAX, 1'b1)},
      // equal deltas: y is the major axis
      '{start_item(CZERO, CZERO, 10'd3, 10'd3), 1'b1, 1'b1, pix(CZERO, CZERO, 1'b0)},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b1, 1'b0, NO_PIXEL},
      // corner to corner, then a new start drops it mid-line
      '{start_item(CMAX, CZERO, CZERO, CMAX), 1'b1, 1'b1, pix(CMAX, CZERO, 1'b0)},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{start_item(CZERO, CMAX, CMAX, CZERO), 1'b1, 1'b1, pix(CZERO, CMAX, 1'b0)},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      // shallow line running toward smaller x and y, walked to its end
      '{start_item(10'd10, 10'd500, 10'd2, 10'd497), 1'b1, 1'b1,
        pix(10'd10, 10'd500, 1'b0)},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b0, 1'b0, NO_PIXEL},
      '{step_item(), 1'b1, 1'b0, NO_PIXEL}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (dir_table[i]) begin
      send_item(dir_table[i].item, produced, p);
      if (dir_table[i].typed) begin
        if (dir_table[i].has_pixel) pixel_queue.push_back(dir_table[i].pixel);
      end else if (produced) begin
        pixel_queue.push_back(p);
      end
    end

    // random lines under three idle patterns
    random_lines(PHASE_PIXELS);
    idle_pct = 82;
    stall_pct <= 33;
    random_lines(PHASE_PIXELS);
    idle_pct = 0;
    stall_pct <= 0;
    random_lines(PHASE_PIXELS);

    // long shallow line across the whole range, walked part way
    draw_line(0, 0, COORD_MAX, COORD_MAX / 2, LONG_STEPS);
    in_valid <= 1'b0;

    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
